// File: design/qbwa_pkg.sv
package qbwa_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CORNER_TL = 3'd0,
    REG_CORNER_TR = 3'd1,
    REG_CORNER_BR = 3'd2,
    REG_CORNER_BL = 3'd3,
    REG_CAM_W     = 3'd4,
    REG_CAM_H     = 3'd5,
    REG_WORK_W    = 3'd6,
    REG_WORK_H    = 3'd7
  } cfg_reg_t;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COORD_W    = 16;
  localparam int NUM_AXES   = 2;
  localparam int AXIS_X     = 0;
  localparam int AXIS_Y     = 1;

  localparam int SRC_MAX = 32767;
  localparam int SRC_MIN = -32768;

  // Corner packing: x in the low half, y in the high half.
  localparam logic [CFG_DATA_W-1:0] CORNER_TL_RST = 32'd0;
  localparam logic [CFG_DATA_W-1:0] CORNER_TR_RST = 32'd640;
  localparam logic [CFG_DATA_W-1:0] CORNER_BR_RST = 32'd31457920;
  localparam logic [CFG_DATA_W-1:0] CORNER_BL_RST = 32'd31457280;

  localparam int CAM_W_RST  = 640;
  localparam int CAM_H_RST  = 480;
  localparam int WORK_W_RST = 640;
  localparam int WORK_H_RST = 480;

endpackage

// File: design/quad_bilinear_warp_address.sv
// An accepted input beat passes the skid register (if that took the beat), stages s0 to s5,
// the divider and the q, p, l, o and output registers on its way to the output.
// Throughput: one beat per cycle unless out_stall holds the pipeline; two restoring dividers
// produce one quotient bit per stage; their depth, 2*DIM_BITS+19 stages, sets the latency.
// Reset (rst_n low, synchronous) empties the pipeline and the skid register and loads the
// configuration registers with their defaults.
module quad_bilinear_warp_address
  import qbwa_pkg::*;
#(
  parameter int DIM_BITS = 12,
  parameter int CHANNELS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [DIM_BITS-1:0]          in_dest_x,
  input  logic [DIM_BITS-1:0]          in_dest_y,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_W-1:0]    out_src_x,
  output logic signed [COORD_W-1:0]    out_src_y,
  output logic [2*DIM_BITS+1:0]        out_src_offset,
  output logic                         out_in_range
);

  localparam int D   = DIM_BITS;
  localparam int AW  = D + 18;        // edge points A and B
  localparam int NW  = 2*D + 20;      // numerator N, signed
  localparam int QW  = 2*D + 19;      // magnitude of N and of the quotient
  localparam int MW  = 2*D;           // divisor W*H
  localparam int PW  = QW + D + 2;    // sy * cam_width
  localparam int LW  = QW + D + 3;    // sx + sy * cam_width
  localparam int OW  = QW + D + 5;    // byte offset, exact
  localparam int OFW = 2*D + 2;       // byte offset field

  // ---------------------------------------------------------------- config
  logic [CFG_DATA_W-1:0] tl_r, tr_r, br_r, bl_r;
  logic [D-1:0]          cam_w_r, cam_h_r, work_w_r, work_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r     <= CORNER_TL_RST;
      tr_r     <= CORNER_TR_RST;
      br_r     <= CORNER_BR_RST;
      bl_r     <= CORNER_BL_RST;
      cam_w_r  <= D'(CAM_W_RST);
      cam_h_r  <= D'(CAM_H_RST);
      work_w_r <= D'(WORK_W_RST);
      work_h_r <= D'(WORK_H_RST);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CORNER_TL: tl_r     <= cfg_wdata;
        REG_CORNER_TR: tr_r     <= cfg_wdata;
        REG_CORNER_BR: br_r     <= cfg_wdata;
        REG_CORNER_BL: bl_r     <= cfg_wdata;
        REG_CAM_W:     cam_w_r  <= cfg_wdata[D-1:0];
        REG_CAM_H:     cam_h_r  <= cfg_wdata[D-1:0];
        REG_WORK_W:    work_w_r <= cfg_wdata[D-1:0];
        REG_WORK_H:    work_h_r <= cfg_wdata[D-1:0];
        default: ;
      endcase
    end
  end

  // A zero workspace dimension counts as one, so the divisor is never zero.
  logic [D-1:0]         w_eff, h_eff;
  logic signed [D:0]    w_s, h_s, cam_w_s;
  logic [MW-1:0]        m_r, cwch_r;
  logic [OFW-1:0]       tot_r;

  assign w_eff   = (work_w_r == '0) ? D'(1) : work_w_r;
  assign h_eff   = (work_h_r == '0) ? D'(1) : work_h_r;
  assign w_s     = $signed({1'b0, w_eff});
  assign h_s     = $signed({1'b0, h_eff});
  assign cam_w_s = $signed({1'b0, cam_w_r});

  // Terms that follow from the configuration alone; they settle long before an item needs them.
  always_ff @(posedge clk) begin
    m_r    <= MW'(w_eff) * MW'(h_eff);
    cwch_r <= MW'(cam_w_r) * MW'(cam_h_r);
    tot_r  <= OFW'(cwch_r) * OFW'(CHANNELS);
  end

  logic signed [COORD_W-1:0] c_tl [NUM_AXES];
  logic signed [COORD_W-1:0] c_tr [NUM_AXES];
  logic signed [COORD_W-1:0] c_br [NUM_AXES];
  logic signed [COORD_W-1:0] c_bl [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      c_tl[a] = $signed(tl_r[COORD_W*a +: COORD_W]);
      c_tr[a] = $signed(tr_r[COORD_W*a +: COORD_W]);
      c_br[a] = $signed(br_r[COORD_W*a +: COORD_W]);
      c_bl[a] = $signed(bl_r[COORD_W*a +: COORD_W]);
    end
  end

  // ------------------------------------------------------ flow control
  // Every stage moves together; the skid register keeps in_stall a registered signal.
  logic         en;
  logic         in_acc;
  logic         skid_full_r;
  logic [D-1:0] skid_dx_r, skid_dy_r;

  logic         out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = skid_full_r;
  assign in_acc   = in_valid && !skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (en) begin
      skid_full_r <= 1'b0;
    end else if (in_acc) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid_dx_r <= in_dest_x;
      skid_dy_r <= in_dest_y;
    end
  end

  // ---------------------------------------------------- pipeline state
  logic         s0_v_r;
  logic [D-1:0] s0_dx_r, s0_dy_r;

  logic                 s1_v_r;
  logic [D-1:0]         s1_dy_r;
  logic signed [AW-1:0] s1_tlw_r [NUM_AXES];
  logic signed [AW-1:0] s1_tld_r [NUM_AXES];
  logic signed [AW-1:0] s1_blw_r [NUM_AXES];
  logic signed [AW-1:0] s1_bld_r [NUM_AXES];

  logic                 s2_v_r;
  logic [D-1:0]         s2_dy_r;
  logic signed [AW-1:0] s2_a_r [NUM_AXES];
  logic signed [AW-1:0] s2_b_r [NUM_AXES];

  logic                 s3_v_r;
  logic [D-1:0]         s3_dy_r;
  logic signed [AW-1:0] s3_a_r [NUM_AXES];
  logic signed [AW:0]   s3_d_r [NUM_AXES];

  logic                 s4_v_r;
  logic signed [NW-1:0] s4_ah_r [NUM_AXES];
  logic signed [NW-1:0] s4_dd_r [NUM_AXES];

  logic                 s5_v_r;
  logic signed [NW-1:0] s5_n_r [NUM_AXES];

  // Divider: entry k holds the partial remainder and the dividend with k quotient bits
  // shifted in at the bottom. Entry 0 is loaded with |N|.
  logic          dv_v_r   [QW+1];
  logic          dv_neg_r [NUM_AXES][QW+1];
  logic [MW-1:0] dv_rem_r [NUM_AXES][QW+1];
  logic [QW-1:0] dv_num_r [NUM_AXES][QW+1];

  logic [MW-1:0] dv_rem_nxt [NUM_AXES][QW];
  logic [QW-1:0] dv_num_nxt [NUM_AXES][QW];

  logic                 q_v_r;
  logic signed [QW:0]   q_r [NUM_AXES];

  logic                      p_v_r;
  logic signed [QW:0]        p_sx_r;
  logic signed [PW-1:0]      p_prod_r;
  logic signed [COORD_W-1:0] p_sat_r [NUM_AXES];

  logic                      l_v_r;
  logic signed [LW-1:0]      l_lin_r;
  logic signed [COORD_W-1:0] l_sat_r [NUM_AXES];

  logic                      o_v_r;
  logic signed [OW-1:0]      o_off_r;
  logic signed [COORD_W-1:0] o_sat_r [NUM_AXES];

  logic                      out_in_range_r;
  logic [OFW-1:0]            out_src_offset_r;
  logic signed [COORD_W-1:0] out_src_x_r, out_src_y_r;

  // ------------------------------------------------- combinational parts
  logic         s0_v_nxt;
  logic [D-1:0] s0_dx_nxt, s0_dy_nxt;

  assign s0_v_nxt  = skid_full_r || in_acc;
  assign s0_dx_nxt = skid_full_r ? skid_dx_r : in_dest_x;
  assign s0_dy_nxt = skid_full_r ? skid_dy_r : in_dest_y;

  logic signed [D:0]    dx_s, dy_s;
  logic signed [AW-1:0] s1_tlw_nxt [NUM_AXES];
  logic signed [AW-1:0] s1_tld_nxt [NUM_AXES];
  logic signed [AW-1:0] s1_blw_nxt [NUM_AXES];
  logic signed [AW-1:0] s1_bld_nxt [NUM_AXES];
  logic signed [AW-1:0] dtop [NUM_AXES];
  logic signed [AW-1:0] dbot [NUM_AXES];

  assign dx_s = $signed({1'b0, s0_dx_r});
  assign dy_s = $signed({1'b0, s3_dy_r});

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dtop[a]       = AW'(c_tr[a]) - AW'(c_tl[a]);
      dbot[a]       = AW'(c_br[a]) - AW'(c_bl[a]);
      s1_tlw_nxt[a] = AW'(c_tl[a]) * AW'(w_s);
      s1_blw_nxt[a] = AW'(c_bl[a]) * AW'(w_s);
      s1_tld_nxt[a] = dtop[a] * AW'(dx_s);
      s1_bld_nxt[a] = dbot[a] * AW'(dx_s);
    end
  end

  logic signed [NW-1:0] s5_abs [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s5_abs[a] = s5_n_r[a][NW-1] ? -s5_n_r[a] : s5_n_r[a];
    end
  end

  // One restoring step per divider stage.
  logic [MW:0] dv_t;
  logic [MW:0] dv_sub;
  logic        dv_ge;

  always_comb begin
    dv_t   = '0;
    dv_sub = '0;
    dv_ge  = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < QW; k++) begin
        dv_t   = {dv_rem_r[a][k], dv_num_r[a][k][QW-1]};
        dv_sub = dv_t - {1'b0, m_r};
        dv_ge  = (dv_t >= {1'b0, m_r});
        dv_rem_nxt[a][k] = dv_ge ? dv_sub[MW-1:0] : dv_t[MW-1:0];
        dv_num_nxt[a][k] = {dv_num_r[a][k][QW-2:0], dv_ge};
      end
    end
  end

  logic signed [QW:0] q_nxt [NUM_AXES];
  logic signed [QW:0] q_mag [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      q_mag[a] = $signed({1'b0, dv_num_r[a][QW]});
      q_nxt[a] = dv_neg_r[a][QW] ? -q_mag[a] : q_mag[a];
    end
  end

  logic signed [COORD_W-1:0] p_sat_nxt [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (q_r[a] > $signed((QW+1)'(SRC_MAX))) begin
        p_sat_nxt[a] = COORD_W'(SRC_MAX);
      end else if (q_r[a] < $signed((QW+1)'(SRC_MIN))) begin
        p_sat_nxt[a] = COORD_W'(SRC_MIN);
      end else begin
        p_sat_nxt[a] = q_r[a][COORD_W-1:0];
      end
    end
  end

  // The frame test uses the exact offset; a negative offset is never in range.
  logic out_ok_nxt;

  assign out_ok_nxt = !o_off_r[OW-1] && (o_off_r[OW-2:0] < (OW-1)'(tot_r));

  // ------------------------------------------------------ valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        dv_v_r[k] <= 1'b0;
      end
      q_v_r       <= 1'b0;
      p_v_r       <= 1'b0;
      l_v_r       <= 1'b0;
      o_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_v_r      <= s0_v_nxt;
      s1_v_r      <= s0_v_r;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      dv_v_r[0]   <= s5_v_r;
      for (int k = 0; k < QW; k++) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      q_v_r       <= dv_v_r[QW];
      p_v_r       <= q_v_r;
      l_v_r       <= p_v_r;
      o_v_r       <= l_v_r;
      out_valid_r <= o_v_r;
    end
  end

  // ------------------------------------------------------ data path
  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx_r <= s0_dx_nxt;
      s0_dy_r <= s0_dy_nxt;

      s1_dy_r <= s0_dy_r;
      s2_dy_r <= s1_dy_r;
      s3_dy_r <= s2_dy_r;

      for (int a = 0; a < NUM_AXES; a++) begin
        s1_tlw_r[a] <= s1_tlw_nxt[a];
        s1_tld_r[a] <= s1_tld_nxt[a];
        s1_blw_r[a] <= s1_blw_nxt[a];
        s1_bld_r[a] <= s1_bld_nxt[a];

        // Top and bottom edge points, scaled by W.
        s2_a_r[a] <= s1_tlw_r[a] + s1_tld_r[a];
        s2_b_r[a] <= s1_blw_r[a] + s1_bld_r[a];

        s3_a_r[a] <= s2_a_r[a];
        s3_d_r[a] <= (AW+1)'(s2_b_r[a]) - (AW+1)'(s2_a_r[a]);

        s4_ah_r[a] <= NW'(s3_a_r[a]) * NW'(h_s);
        s4_dd_r[a] <= NW'(s3_d_r[a]) * NW'(dy_s);

        s5_n_r[a] <= s4_ah_r[a] + s4_dd_r[a];

        // Sign and magnitude division truncates toward zero.
        dv_neg_r[a][0] <= s5_n_r[a][NW-1];
        dv_rem_r[a][0] <= '0;
        dv_num_r[a][0] <= s5_abs[a][QW-1:0];
        for (int k = 0; k < QW; k++) begin
          dv_neg_r[a][k+1] <= dv_neg_r[a][k];
          dv_rem_r[a][k+1] <= dv_rem_nxt[a][k];
          dv_num_r[a][k+1] <= dv_num_nxt[a][k];
        end

        q_r[a]     <= q_nxt[a];
        p_sat_r[a] <= p_sat_nxt[a];
        l_sat_r[a] <= p_sat_r[a];
        o_sat_r[a] <= l_sat_r[a];
      end

      p_sx_r   <= q_r[AXIS_X];
      p_prod_r <= PW'(q_r[AXIS_Y]) * PW'(cam_w_s);

      l_lin_r  <= LW'(p_sx_r) + LW'(p_prod_r);

      o_off_r  <= OW'(l_lin_r) * OW'(CHANNELS);

      out_src_x_r      <= o_sat_r[AXIS_X];
      out_src_y_r      <= o_sat_r[AXIS_Y];
      out_in_range_r   <= out_ok_nxt;
      out_src_offset_r <= out_ok_nxt ? o_off_r[OFW-1:0] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_src_x      = out_src_x_r;
  assign out_src_y      = out_src_y_r;
  assign out_src_offset = out_src_offset_r;
  assign out_in_range   = out_in_range_r;

endmodule

// File: tb/quad_bilinear_warp_address_tb.sv
`timescale 1ns / 100ps

module quad_bilinear_warp_address_tb
  import qbwa_pkg::*;
;

  localparam int DIM_BITS      = 12;
  localparam int CHANNELS      = 3;
  localparam int OFF_W         = 2 * DIM_BITS + 2;
  localparam int DIM_MAX       = (1 << DIM_BITS) - 1;
  localparam int MAX_WAIT      = 11;
  localparam int DRAIN_CYCLES  = 2 * DIM_BITS + 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 73;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic [OFF_W-1:0]          offset;
    logic                      in_range;
  } src_addr_t;

  class warp_scoreboard;
    logic [CFG_DATA_W-1:0] corner [4];
    logic [DIM_BITS-1:0]   cam_w, cam_h, work_w, work_h;
    src_addr_t             pending [$];
    int                    errors;

    function new();
      corner[REG_CORNER_TL] = CORNER_TL_RST;
      corner[REG_CORNER_TR] = CORNER_TR_RST;
      corner[REG_CORNER_BR] = CORNER_BR_RST;
      corner[REG_CORNER_BL] = CORNER_BL_RST;
      cam_w  = DIM_BITS'(CAM_W_RST);
      cam_h  = DIM_BITS'(CAM_H_RST);
      work_w = DIM_BITS'(WORK_W_RST);
      work_h = DIM_BITS'(WORK_H_RST);
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CAM_W:  cam_w  = data[DIM_BITS-1:0];
        REG_CAM_H:  cam_h  = data[DIM_BITS-1:0];
        REG_WORK_W: work_w = data[DIM_BITS-1:0];
        REG_WORK_H: work_h = data[DIM_BITS-1:0];
        default:    corner[idx] = data;
      endcase
    endfunction

    function longint corner_coord(cfg_reg_t idx, int axis);
      logic signed [COORD_W-1:0] c;
      c = corner[idx][axis*COORD_W +: COORD_W];
      return longint'(c);
    endfunction

    // Blend along the top and bottom edges by u, then between them by v. The numerator is
    // exact, and the signed division truncates toward zero.
    function longint blend_axis(int axis, longint dx, longint dy, longint w, longint h);
      longint tl, tr, br, bl, top, bottom;
      tl = corner_coord(REG_CORNER_TL, axis);
      tr = corner_coord(REG_CORNER_TR, axis);
      br = corner_coord(REG_CORNER_BR, axis);
      bl = corner_coord(REG_CORNER_BL, axis);
      top    = tl * w + (tr - tl) * dx;
      bottom = bl * w + (br - bl) * dx;
      return (top * h + (bottom - top) * dy) / (w * h);
    endfunction

    function logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > SRC_MAX) v = SRC_MAX;
      if (v < SRC_MIN) v = SRC_MIN;
      return v[COORD_W-1:0];
    endfunction

    function void note_input(logic [DIM_BITS-1:0] dest_x, logic [DIM_BITS-1:0] dest_y);
      longint    w, h, sx, sy, offset, frame;
      src_addr_t e;
      w  = (work_w == 0) ? 1 : longint'(work_w);
      h  = (work_h == 0) ? 1 : longint'(work_h);
      sx = blend_axis(AXIS_X, longint'(dest_x), longint'(dest_y), w, h);
      sy = blend_axis(AXIS_Y, longint'(dest_x), longint'(dest_y), w, h);
      // The address uses the unsaturated coordinates.
      offset = (sx + sy * longint'(cam_w)) * CHANNELS;
      frame  = longint'(cam_w) * longint'(cam_h) * CHANNELS;
      e.src_x    = clamp_coord(sx);
      e.src_y    = clamp_coord(sy);
      e.in_range = (offset >= 0) && (offset < frame);
      e.offset   = e.in_range ? offset[OFF_W-1:0] : '0;
      pending.push_back(e);
    endfunction

    function void check_result(src_addr_t got);
      src_addr_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result beat: src_x=%0d src_y=%0d offset=%0d in_range=%0b",
                   $time, got.src_x, got.src_y, got.offset, got.in_range);
        return;
      end
      e = pending.pop_front();
      if (got.src_x !== e.src_x || got.src_y !== e.src_y ||
          got.offset !== e.offset || got.in_range !== e.in_range) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: mismatch: expected src_x=%0d src_y=%0d offset=%0d in_range=%0b,",
                    " got src_x=%0d src_y=%0d offset=%0d in_range=%0b"},
                   $time, e.src_x, e.src_y, e.offset, e.in_range,
                   got.src_x, got.src_y, got.offset, got.in_range);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [DIM_BITS-1:0]   in_dest_x = '0;
  logic [DIM_BITS-1:0]   in_dest_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_src_x;
  logic signed [COORD_W-1:0] out_src_y;
  logic [OFF_W-1:0]      out_src_offset;
  logic                  out_in_range;

  warp_scoreboard sb;
  bit             in_burst  = 1'b0;
  bit             out_burst = 1'b0;
  int             out_hold  = 0;

  quad_bilinear_warp_address #(
    .DIM_BITS(DIM_BITS),
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_dest_x     (in_dest_x),
    .in_dest_y     (in_dest_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_src_x     (out_src_x),
    .out_src_y     (out_src_y),
    .out_src_offset(out_src_offset),
    .out_in_range  (out_in_range)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Now and then a side switches between random waits and back-to-back beats.
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1, 2:    return DIM_MAX;
      3:       return 1;
      4, 5, 6: return $urandom_range(1, 64);
      default: return $urandom_range(1, DIM_MAX);
    endcase
  endfunction

  always @(posedge clk) begin
    src_addr_t seen;
    int        hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      hold = out_hold;
      if (out_valid && !out_stall) begin
        seen.src_x    = out_src_x;
        seen.src_y    = out_src_y;
        seen.offset   = out_src_offset;
        seen.in_range = out_in_range;
        sb.check_result(seen);
        hold = draw_wait(out_burst);
      end
      out_stall <= (hold > 0);
      out_hold = (hold > 0) ? hold - 1 : 0;
    end
  end

  // Called just after a rising edge; returns once in_stall reads low after an edge, by which the beat is taken.
  // Only the low DIM_BITS bits of each coordinate are sent.
  task automatic send_beat(int dx, int dy);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_dest_x <= dx[DIM_BITS-1:0];
    in_dest_y <= dy[DIM_BITS-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(dx[DIM_BITS-1:0], dy[DIM_BITS-1:0]);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Size registers sometimes carry junk above their width, which must be dropped.
  task automatic write_dim(cfg_reg_t idx, int val);
    logic [CFG_DATA_W-1:0] data;
    data = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
    data[DIM_BITS-1:0] = val[DIM_BITS-1:0];
    write_reg(idx, data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    int                 cw, ch, jit;
    logic [COORD_W-1:0] cx [4];
    logic [COORD_W-1:0] cy [4];
    logic [COORD_W-1:0] extremes [4];
    extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    cw = pick_dim();
    ch = pick_dim();
    case ($urandom_range(0, 3))
      0: begin
        // Quad inside the camera frame.
        for (int i = 0; i < 4; i++) begin
          cx[i] = COORD_W'((cw > 0) ? $urandom_range(0, cw - 1) : 0);
          cy[i] = COORD_W'((ch > 0) ? $urandom_range(0, ch - 1) : 0);
        end
      end
      1: begin
        for (int i = 0; i < 4; i++) begin
          cx[i] = COORD_W'($urandom());
          cy[i] = COORD_W'($urandom());
        end
      end
      2: begin
        for (int i = 0; i < 4; i++) begin
          cx[i] = extremes[$urandom_range(0, 3)];
          cy[i] = extremes[$urandom_range(0, 3)];
        end
      end
      default: begin
        // Nearly the full frame, shifted by a few pixels.
        jit = $urandom_range(0, 8) - 4;
        cx[REG_CORNER_TL] = COORD_W'(jit);      cy[REG_CORNER_TL] = COORD_W'(jit);
        cx[REG_CORNER_TR] = COORD_W'(cw + jit); cy[REG_CORNER_TR] = COORD_W'(jit);
        cx[REG_CORNER_BR] = COORD_W'(cw + jit); cy[REG_CORNER_BR] = COORD_W'(ch + jit);
        cx[REG_CORNER_BL] = COORD_W'(jit);      cy[REG_CORNER_BL] = COORD_W'(ch + jit);
      end
    endcase
    for (int i = 0; i < 4; i++) write_reg(cfg_reg_t'(i), {cy[i], cx[i]});
    write_dim(REG_CAM_W, cw);
    write_dim(REG_CAM_H, ch);
    write_dim(REG_WORK_W, pick_dim());
    write_dim(REG_WORK_H, pick_dim());
  endtask

  task automatic random_items(int count);
    int ww, wh;
    ww = int'(sb.work_w);
    wh = int'(sb.work_h);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) != 0)
        send_beat($urandom_range(0, (ww < DIM_MAX) ? ww : DIM_MAX),
                  $urandom_range(0, (wh < DIM_MAX) ? wh : DIM_MAX));
      else
        send_beat($urandom(), $urandom());
    end
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset corners and sizes, with the field extremes.
    send_beat(0, 0);
    send_beat(DIM_MAX, DIM_MAX);
    send_beat(0, DIM_MAX);
    send_beat(DIM_MAX, 0);
    send_beat(639, 479);
    send_beat(640, 480);
    send_beat(320, 240);
    send_beat(12'hAAA, 12'h555);
    send_beat(12'h555, 12'hAAA);

    // Extreme corners over a one-pixel workspace: coordinates far beyond 16 bits saturate.
    settle();
    write_reg(REG_CORNER_TL, {16'h8000, 16'h8000});
    write_reg(REG_CORNER_TR, {16'h8000, 16'h7FFF});
    write_reg(REG_CORNER_BR, {16'h7FFF, 16'h7FFF});
    write_reg(REG_CORNER_BL, {16'h7FFF, 16'h8000});
    write_reg(REG_CAM_W, 32'hFFFF_FFFF);
    write_reg(REG_CAM_H, 32'hFFFF_FFFF);
    write_dim(REG_WORK_W, 1);
    write_dim(REG_WORK_H, 1);
    send_beat(0, 0);
    send_beat(1, 0);
    send_beat(1, 1);
    send_beat(0, 1);
    send_beat(DIM_MAX, DIM_MAX);

    // Zero workspace sizes count as one; a zero camera width leaves an empty frame.
    settle();
    write_reg(REG_CORNER_TL, {16'd0, 16'd0});
    write_reg(REG_CORNER_TR, {16'd0, 16'd3});
    write_reg(REG_CORNER_BR, {16'd2, 16'd3});
    write_reg(REG_CORNER_BL, {16'd2, 16'd0});
    write_dim(REG_CAM_W, 0);
    write_dim(REG_CAM_H, 5);
    write_dim(REG_WORK_W, 0);
    write_dim(REG_WORK_H, 0);
    send_beat(0, 0);
    send_beat(1, 1);
    send_beat(DIM_MAX, 7);

    // Small frame: columns past the camera width wrap into later rows, and a negative
    // corner gives an offset below zero.
    settle();
    write_reg(REG_CORNER_TL, {16'd0, 16'hFFFE});
    write_reg(REG_CORNER_TR, {16'd0, 16'd8});
    write_reg(REG_CORNER_BR, {16'd4, 16'd8});
    write_reg(REG_CORNER_BL, {16'd4, 16'd0});
    write_dim(REG_CAM_W, 4);
    write_dim(REG_CAM_H, 4);
    write_dim(REG_WORK_W, 4);
    write_dim(REG_WORK_H, 4);
    send_beat(0, 0);
    send_beat(3, 1);
    send_beat(4, 3);
    send_beat(0, 3);
    send_beat(4, 4);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      random_setup();
      random_items(PHASE_ITEMS);
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/qbwa_pkg.sv
design/quad_bilinear_warp_address.sv
tb/quad_bilinear_warp_address_tb.sv
